// File: rtl/twrsm_pkg.sv
// Package for the three-wire serial master: phase and request codes, field widths,
// and the BCD encode/decode helpers used by the core.
// No dependencies.
package twrsm_pkg;

   localparam int unsigned AddrWidth  = 8;
   localparam int unsigned ValueWidth = 7;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned ReqTdataWidth = 16;
   localparam int unsigned RspTdataWidth = 16;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_SPARE = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_CMD   = 3'd1,
      PH_WDATA = 3'd2,
      PH_RDATA = 3'd3,
      PH_END   = 3'd4
   } phase_type;

   // Pin and status levels for one tick
   typedef struct packed {
      logic [ByteWidth-1:0] read_value;
      logic                 done;
      logic                 busy;
      logic                 drive;
      logic                 dout;
      logic                 clk;
      logic                 en;
   } result_type;

   // Packed BCD of a 7-bit value; tens come from a multiply by 205/2048
   function automatic logic [ByteWidth-1:0] to_bcd(input logic [ValueWidth-1:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [ValueWidth-1:0] tens_x10;
      logic [ValueWidth-1:0] units;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = ValueWidth'({tens, 3'b000}) + ValueWidth'({tens, 1'b0});
      units    = v - tens_x10;
      return {tens, units[3:0]};
   endfunction

   // high nibble * 10 + low nibble
   function automatic logic [ByteWidth-1:0] from_bcd(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] hi_x10;
      hi_x10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
      return hi_x10 + {4'b0000, b[3:0]};
   endfunction

endpackage

// File: rtl/three_wire_rtc_serial_master_core.sv
// Three-wire serial master core: tick-driven sequencer for command and data bytes.
// Depends on twrsm_pkg.
//
// Each request item is one tick of the serial waveform and yields exactly one response
// item holding the pin levels for that tick. The core takes one item every clock cycle
// and registers its response; the response side has a two-entry buffer, so a stalled
// response holds up the request side only once both entries are full. A write or read
// request is honored only while the sequencer is idle. A transaction runs a request tick,
// 16 command ticks, 16 data ticks and an end tick that carries done and the decoded read
// value.
module three_wire_rtc_serial_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] reg_addr, [14:8] value, [15] sda_in
   input  logic [twrsm_pkg::ReqTdataWidth-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] enable_pin, [1] clock_pin, [2] data_out, [3] data_drive, [4] busy_res,
   // [12:5] read_value, [15:13] zero
   output logic [twrsm_pkg::RspTdataWidth-1:0] rsp_tdata,
   // done_res
   output logic        rsp_tlast
);

   twrsm_pkg::phase_type phase_ff, phase_in;
   logic [twrsm_pkg::CountWidth-1:0] bit_count_ff, bit_count_in;
   logic clock_high_ff, clock_high_in;
   logic is_read_ff, is_read_in;
   logic [twrsm_pkg::ByteWidth-1:0] tx_shift_ff, tx_shift_in;
   logic [twrsm_pkg::ByteWidth-1:0] data_byte_ff, data_byte_in;
   logic [twrsm_pkg::ByteWidth-1:0] rx_shift_ff, rx_shift_in;
   logic [twrsm_pkg::ByteWidth-1:0] last_read_ff, last_read_in;

   twrsm_pkg::result_type result;
   twrsm_pkg::result_type out_ff, out_in;
   twrsm_pkg::result_type skid_ff, skid_in;
   logic out_vld_ff, out_vld_in;
   logic skid_vld_ff, skid_vld_in;

   twrsm_pkg::req_code_type req_code;
   logic [twrsm_pkg::AddrWidth-1:0]  req_addr;
   logic [twrsm_pkg::ValueWidth-1:0] req_value;
   logic req_sda;
   logic req_start;
   logic req_is_read;
   logic accept;
   logic out_take;
   logic [twrsm_pkg::CountWidth-1:0] cnt_inc;
   logic last_bit;
   logic [twrsm_pkg::ByteWidth-1:0] tx_next;

   assign req_code    = twrsm_pkg::req_code_type'(req_tuser);
   assign req_addr    = req_tdata[7:0];
   assign req_value   = req_tdata[14:8];
   assign req_sda     = req_tdata[15];
   assign req_is_read = (req_code == twrsm_pkg::REQ_READ);
   assign req_start   = (req_code == twrsm_pkg::REQ_WRITE) || req_is_read;

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_take   = out_vld_ff && rsp_tready;

   assign cnt_inc  = bit_count_ff + twrsm_pkg::CountWidth'(1);
   assign last_bit = cnt_inc[twrsm_pkg::CountWidth-1];

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         twrsm_pkg::PH_IDLE: begin
            if (req_start) phase_in = twrsm_pkg::PH_CMD;
         end
         twrsm_pkg::PH_CMD: begin
            if (clock_high_ff && last_bit)
               phase_in = is_read_ff ? twrsm_pkg::PH_RDATA : twrsm_pkg::PH_WDATA;
         end
         twrsm_pkg::PH_WDATA, twrsm_pkg::PH_RDATA: begin
            if (clock_high_ff && last_bit) phase_in = twrsm_pkg::PH_END;
         end
         twrsm_pkg::PH_END: phase_in = twrsm_pkg::PH_IDLE;
         default: phase_in = twrsm_pkg::PH_IDLE;
      endcase
   end

   // Datapath and pin levels
   always_comb begin
      bit_count_in  = bit_count_ff;
      clock_high_in = clock_high_ff;
      is_read_in    = is_read_ff;
      tx_shift_in   = tx_shift_ff;
      data_byte_in  = data_byte_ff;
      rx_shift_in   = rx_shift_ff;
      last_read_in  = last_read_ff;
      tx_next       = tx_shift_ff;
      result        = '0;
      result.drive  = 1'b1;
      unique case (phase_ff)
         twrsm_pkg::PH_CMD, twrsm_pkg::PH_WDATA: begin
            result.en   = 1'b1;
            result.busy = 1'b1;
            if (!clock_high_ff) begin
               result.clk    = 1'b1;
               result.dout   = tx_shift_ff[0];
               clock_high_in = 1'b1;
            end else begin
               clock_high_in = 1'b0;
               tx_next       = tx_shift_ff >> 1;
               bit_count_in  = cnt_inc;
               if (last_bit) begin
                  bit_count_in = '0;
                  if (phase_ff == twrsm_pkg::PH_CMD) begin
                     if (is_read_ff) begin
                        rx_shift_in  = '0;
                        result.drive = 1'b0;
                     end else begin
                        tx_next = data_byte_ff;
                     end
                  end
               end
               tx_shift_in = tx_next;
               result.dout = result.drive & tx_next[0];
            end
         end
         twrsm_pkg::PH_RDATA: begin
            result.en    = 1'b1;
            result.busy  = 1'b1;
            result.drive = 1'b0;
            if (!clock_high_ff) begin
               // sample before the rising edge
               rx_shift_in   = {req_sda, rx_shift_ff[7:1]};
               result.clk    = 1'b1;
               clock_high_in = 1'b1;
            end else begin
               clock_high_in = 1'b0;
               bit_count_in  = cnt_inc;
               if (last_bit) begin
                  bit_count_in = '0;
                  last_read_in = twrsm_pkg::from_bcd(rx_shift_ff);
               end
            end
         end
         twrsm_pkg::PH_END: begin
            result.busy       = 1'b1;
            result.done       = 1'b1;
            result.read_value = is_read_ff ? last_read_ff : '0;
         end
         default: begin
            if (req_start) begin
               is_read_in    = req_is_read;
               tx_shift_in   = {req_addr[7:1], req_is_read};
               data_byte_in  = req_is_read ? '0 : twrsm_pkg::to_bcd(req_value);
               bit_count_in  = '0;
               clock_high_in = 1'b0;
               result.en     = 1'b1;
               result.busy   = 1'b1;
               result.dout   = req_is_read;
            end
         end
      endcase
   end

   // Two-entry response buffer
   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (accept) begin
         if (!out_vld_ff || out_take) begin
            out_in     = result;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = result;
            skid_vld_in = 1'b1;
         end
      end else if (out_take) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= twrsm_pkg::PH_IDLE;
         bit_count_ff  <= '0;
         clock_high_ff <= 1'b0;
         is_read_ff    <= 1'b0;
         tx_shift_ff   <= '0;
         data_byte_ff  <= '0;
         rx_shift_ff   <= '0;
         last_read_ff  <= '0;
         out_vld_ff    <= 1'b0;
         skid_vld_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            clock_high_ff <= clock_high_in;
            is_read_ff    <= is_read_in;
            tx_shift_ff   <= tx_shift_in;
            data_byte_ff  <= data_byte_in;
            rx_shift_ff   <= rx_shift_in;
            last_read_ff  <= last_read_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_ff.done;
   assign rsp_tdata  = {3'b000, out_ff.read_value, out_ff.busy, out_ff.drive,
                        out_ff.dout, out_ff.clk, out_ff.en};

endmodule

// File: rtl/twrsm_checker.sv
// Port-level checks for three_wire_rtc_serial_master_core, attached by bind.
// Depends on twrsm_pkg for port widths.
module twrsm_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [twrsm_pkg::RspTdataWidth-1:0] rsp_tdata,
   input logic rsp_tlast
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the request side stalls only while responses back up
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no pending response");

   // a fresh response must come from an accepted request item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && rsp_tvalid && !$past(rsp_tvalid))
         |-> $past(req_tvalid && req_tready))
      else $error("response without an accepted request item");

   // hold a stalled response item unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
         |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response item changed");

   // the end tick is busy with enable and clock low
   a_end_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[4] && !rsp_tdata[0] && !rsp_tdata[1]))
      else $error("end tick pin levels wrong");

endmodule

bind three_wire_rtc_serial_master_core twrsm_checker u_twrsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: test/three_wire_rtc_serial_master_core_test.sv
// Testbench for three_wire_rtc_serial_master_core: streams tick items into the core and
// checks every returned pin/status item against a tick-level predictor of the sequencer.
// Depends on twrsm_pkg and the core RTL.
module three_wire_rtc_serial_master_core_test;

   localparam int unsigned WatchdogLimit = 5000;
   localparam int unsigned DrainCycles   = 20;
   localparam int unsigned RandomItems   = 720;

   typedef struct {
      twrsm_pkg::req_code_type                kind;
      logic [twrsm_pkg::AddrWidth-1:0]        addr;
      logic [twrsm_pkg::ValueWidth-1:0]       value;
      logic                                   sda;
   } tick_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [7:0] reg_addr, [14:8] value, [15] sda_in
   logic [twrsm_pkg::ReqTdataWidth-1:0] req_tdata = '0;
   // [1:0] req_type
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [0] enable_pin, [1] clock_pin, [2] data_out, [3] data_drive, [4] busy_res,
   // [12:5] read_value, [15:13] zero
   logic [twrsm_pkg::RspTdataWidth-1:0] rsp_tdata;
   // done_res
   logic rsp_tlast;

   three_wire_rtc_serial_master_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   tick_item_type          pending_ticks[$];
   twrsm_pkg::result_type  expected_pins[$];
   int unsigned            mismatches = 0;

   // Sequencer mirror
   twrsm_pkg::phase_type                  seq_phase  = twrsm_pkg::PH_IDLE;
   logic [twrsm_pkg::CountWidth-1:0]      bit_index  = '0;
   logic                                  clk_high   = 1'b0;
   logic                                  rd_flag    = 1'b0;
   logic [twrsm_pkg::ByteWidth-1:0]       shift_out  = '0;
   logic [twrsm_pkg::ByteWidth-1:0]       wr_byte    = '0;
   logic [twrsm_pkg::ByteWidth-1:0]       shift_in   = '0;
   logic [twrsm_pkg::ByteWidth-1:0]       rd_decoded = '0;

   function automatic logic [twrsm_pkg::ByteWidth-1:0] bcd_of(
         input logic [twrsm_pkg::ValueWidth-1:0] v);
      int unsigned tens;
      int unsigned units;
      tens  = v / 10;
      units = v % 10;
      return {tens[3:0], units[3:0]};
   endfunction

   // Advance the mirror by one tick and return the pin levels for that tick
   function automatic twrsm_pkg::result_type advance_master(input tick_item_type it);
      twrsm_pkg::result_type r;
      r = '0;
      r.drive = 1'b1;
      case (seq_phase)
         twrsm_pkg::PH_CMD, twrsm_pkg::PH_WDATA: begin
            r.en   = 1'b1;
            r.busy = 1'b1;
            if (!clk_high) begin
               r.clk    = 1'b1;
               r.dout   = shift_out[0];
               clk_high = 1'b1;
            end else begin
               clk_high  = 1'b0;
               shift_out = shift_out >> 1;
               bit_index = bit_index + 4'd1;
               if (bit_index >= 4'd8) begin
                  bit_index = '0;
                  if (seq_phase == twrsm_pkg::PH_CMD) begin
                     if (rd_flag) begin
                        seq_phase = twrsm_pkg::PH_RDATA;
                        shift_in  = '0;
                        r.drive   = 1'b0;
                     end else begin
                        seq_phase = twrsm_pkg::PH_WDATA;
                        shift_out = wr_byte;
                     end
                  end else begin
                     seq_phase = twrsm_pkg::PH_END;
                  end
               end
               r.dout = r.drive ? shift_out[0] : 1'b0;
            end
         end
         twrsm_pkg::PH_RDATA: begin
            r.en    = 1'b1;
            r.busy  = 1'b1;
            r.drive = 1'b0;
            if (!clk_high) begin
               // sample before the rising edge, LSB arrives first
               shift_in = {it.sda, shift_in[7:1]};
               r.clk    = 1'b1;
               clk_high = 1'b1;
            end else begin
               clk_high  = 1'b0;
               bit_index = bit_index + 4'd1;
               if (bit_index >= 4'd8) begin
                  bit_index  = '0;
                  rd_decoded = {4'b0000, shift_in[7:4]} * 8'd10 + {4'b0000, shift_in[3:0]};
                  seq_phase  = twrsm_pkg::PH_END;
               end
            end
         end
         twrsm_pkg::PH_END: begin
            r.busy       = 1'b1;
            r.done       = 1'b1;
            r.read_value = rd_flag ? rd_decoded : '0;
            seq_phase    = twrsm_pkg::PH_IDLE;
         end
         default: begin
            seq_phase = twrsm_pkg::PH_IDLE;
            if (it.kind == twrsm_pkg::REQ_WRITE || it.kind == twrsm_pkg::REQ_READ) begin
               rd_flag   = (it.kind == twrsm_pkg::REQ_READ);
               shift_out = rd_flag ? (it.addr | 8'h01) : (it.addr & 8'hFE);
               wr_byte   = rd_flag ? 8'h00 : bcd_of(it.value);
               bit_index = '0;
               clk_high  = 1'b0;
               seq_phase = twrsm_pkg::PH_CMD;
               r.en      = 1'b1;
               r.busy    = 1'b1;
               r.dout    = shift_out[0];
            end
         end
      endcase
      return r;
   endfunction

   task automatic push_tick(input twrsm_pkg::req_code_type kind,
                            input logic [twrsm_pkg::AddrWidth-1:0] addr,
                            input logic [twrsm_pkg::ValueWidth-1:0] value, input logic sda);
      tick_item_type it;
      it.kind  = kind;
      it.addr  = addr;
      it.value = value;
      it.sda   = sda;
      pending_ticks.push_back(it);
   endtask

   // Request tick, 32 serial ticks and the end tick; sda_bits land on the read sample ticks.
   // busy_req_pct sets how often a tick inside the transaction carries a request anyway.
   task automatic push_transaction(input twrsm_pkg::req_code_type kind, input logic [7:0] addr,
                                   input logic [6:0] value, input logic [7:0] sda_bits,
                                   input int unsigned busy_req_pct);
      twrsm_pkg::req_code_type k;
      logic                    s;
      push_tick(kind, addr, value, 1'($urandom_range(0, 1)));
      for (int i = 1; i < 34; i++) begin
         k = twrsm_pkg::REQ_TICK;
         if ($urandom_range(1, 100) <= busy_req_pct)
            k = twrsm_pkg::req_code_type'($urandom_range(1, 3));
         s = 1'($urandom_range(0, 1));
         if (i >= 17 && i <= 31 && (i % 2) == 1)
            s = sda_bits[(i - 17) / 2];
         push_tick(k, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)), s);
      end
   endtask

   // Driver: bursts of items with random gaps between them
   tick_item_type cur_tick;
   int unsigned   burst_left = 1;
   int unsigned   gap_left   = 0;
   int unsigned   idle_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_pins.push_back(advance_master(cur_tick));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending_ticks.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               cur_tick = pending_ticks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_tick.sda, cur_tick.value, cur_tick.addr};
               req_tuser  <= cur_tick.kind;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: compare each returned item, stall on a pattern that is chosen anew at random
   twrsm_pkg::result_type want_pins;
   int unsigned stall_mode  = 0;
   int unsigned stall_clock = 0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pins.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual tdata %h tlast %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want_pins = expected_pins.pop_front();
            check_field("enable_pin", 8'(want_pins.en), 8'(rsp_tdata[0]));
            check_field("clock_pin", 8'(want_pins.clk), 8'(rsp_tdata[1]));
            check_field("data_out", 8'(want_pins.dout), 8'(rsp_tdata[2]));
            check_field("data_drive", 8'(want_pins.drive), 8'(rsp_tdata[3]));
            check_field("busy_res", 8'(want_pins.busy), 8'(rsp_tdata[4]));
            check_field("read_value", want_pins.read_value, rsp_tdata[12:5]);
            check_field("pad bits", 8'd0, 8'(rsp_tdata[15:13]));
            check_field("done_res", 8'(want_pins.done), 8'(rsp_tlast));
         end
      end
      stall_clock++;
      if (stall_clock % 128 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_clock % 4 != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("three_wire_rtc_serial_master_core_test: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned target;
      // Directed: write extremes, read with nibbles above nine while requests hit every
      // busy tick including the end tick, a back-to-back read of zero, unused request code
      push_transaction(twrsm_pkg::REQ_WRITE, 8'hFF, 7'd99, 8'h00, 0);
      push_transaction(twrsm_pkg::REQ_READ, 8'h00, 7'd0, 8'hFF, 100);
      push_transaction(twrsm_pkg::REQ_READ, 8'hFE, 7'd127, 8'h00, 0);
      push_transaction(twrsm_pkg::REQ_WRITE, 8'h00, 7'd127, 8'hFF, 0);
      push_tick(twrsm_pkg::REQ_SPARE, 8'hFF, 7'd127, 1'b1);
      push_tick(twrsm_pkg::REQ_SPARE, 8'h00, 7'd0, 1'b0);
      push_tick(twrsm_pkg::REQ_TICK, 8'hA5, 7'd55, 1'b1);
      push_transaction(twrsm_pkg::REQ_READ, 8'h81, 7'd42, 8'h59, 0);

      target = pending_ticks.size() + RandomItems;
      while (pending_ticks.size() < target) begin
         if ($urandom_range(0, 4) != 0) begin
            push_transaction($urandom_range(0, 1) ? twrsm_pkg::REQ_READ : twrsm_pkg::REQ_WRITE,
                             8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                             8'($urandom_range(0, 255)), 12);
            repeat ($urandom_range(0, 3))
               push_tick($urandom_range(0, 1) ? twrsm_pkg::REQ_SPARE : twrsm_pkg::REQ_TICK,
                         8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 6))
               push_tick(twrsm_pkg::req_code_type'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() > 0 || req_tvalid || expected_pins.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && expected_pins.size() == 0) begin
         $display("three_wire_rtc_serial_master_core_test: PASS");
      end else begin
         $display("three_wire_rtc_serial_master_core_test: FAIL");
      end
      $finish;
   end

endmodule
